@@ rtl/core/udpc_pkg.sv @@
package udpc_pkg;

  // frame field values
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // byte offsets within the frame
  localparam logic [6:0] OFS_ETYPE_HI = 7'd12;
  localparam logic [6:0] OFS_ETYPE_LO = 7'd13;
  localparam logic [6:0] OFS_L3_START = 7'd14;
  localparam logic [6:0] OFS_V4_PROTO = 7'd23;
  localparam logic [6:0] OFS_V4_DP_HI = 7'd36;
  localparam logic [6:0] OFS_V4_DP_LO = 7'd37;
  localparam logic [6:0] OFS_V6_NXTHD = 7'd20;
  localparam logic [6:0] OFS_V6_DP_HI = 7'd56;
  localparam logic [6:0] OFS_V6_DP_LO = 7'd57;
  localparam logic [6:0] COUNT_MAX    = 7'd127;

  // minimum frame lengths
  localparam logic [7:0] MIN_ETH    = 8'd14;
  localparam logic [7:0] MIN_V4_IP  = 8'd34;
  localparam logic [7:0] MIN_V4_UDP = 8'd42;
  localparam logic [7:0] MIN_V6_IP  = 8'd54;
  localparam logic [7:0] MIN_V6_UDP = 8'd62;

  // register map
  localparam logic REG_LISTEN_PORT = 1'b0;
  localparam logic REG_QUEUE_MASK  = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_REDIRECT      = 3'd0,
    VERDICT_SHORT_ETH     = 3'd1,
    VERDICT_NOT_IP        = 3'd2,
    VERDICT_SHORT_IP      = 3'd3,
    VERDICT_NOT_UDP       = 3'd4,
    VERDICT_SHORT_UDP     = 3'd5,
    VERDICT_PORT_MISMATCH = 3'd6,
    VERDICT_NO_SOCKET     = 3'd7
  } verdict_e;

  // one frame byte as held in the input stage
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [5:0] queue;
  } beat_t;

endpackage

@@ rtl/core/udpc_parser.sv @@
module udpc_parser #(
  parameter int QUEUE_COUNT = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  udpc_pkg::beat_t        beat_i,
  input  logic                   adv_i,
  input  logic [15:0]            listen_port_i,
  input  logic [QUEUE_COUNT-1:0] queue_mask_i,
  output udpc_pkg::verdict_e     verdict_o
);

  logic [6:0]  count_q, count_d;
  logic [15:0] etype_q, etype_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] dport_q, dport_d;
  logic [7:0]  frame_len;
  logic [63:0] mask_ext;
  logic        is_v4, is_v6;

  assign mask_ext = 64'(queue_mask_i);

  // header capture for the current byte
  always_comb begin
    etype_d = etype_q;
    proto_d = proto_q;
    dport_d = dport_q;
    if (count_q == udpc_pkg::OFS_ETYPE_HI) etype_d[15:8] = beat_i.data;
    if (count_q == udpc_pkg::OFS_ETYPE_LO) etype_d[7:0] = beat_i.data;
    if (count_q >= udpc_pkg::OFS_L3_START) begin
      if (etype_q == udpc_pkg::ETYPE_IPV4) begin
        if (count_q == udpc_pkg::OFS_V4_PROTO) proto_d = beat_i.data;
        if (count_q == udpc_pkg::OFS_V4_DP_HI) dport_d[15:8] = beat_i.data;
        if (count_q == udpc_pkg::OFS_V4_DP_LO) dport_d[7:0] = beat_i.data;
      end else if (etype_q == udpc_pkg::ETYPE_IPV6) begin
        if (count_q == udpc_pkg::OFS_V6_NXTHD) proto_d = beat_i.data;
        if (count_q == udpc_pkg::OFS_V6_DP_HI) dport_d[15:8] = beat_i.data;
        if (count_q == udpc_pkg::OFS_V6_DP_LO) dport_d[7:0] = beat_i.data;
      end
    end
    count_d = (count_q == udpc_pkg::COUNT_MAX) ? count_q : count_q + 7'd1;
  end

  assign frame_len = {1'b0, count_q} + 8'd1;
  assign is_v4     = (etype_d == udpc_pkg::ETYPE_IPV4);
  assign is_v6     = (etype_d == udpc_pkg::ETYPE_IPV6);

  // verdict on the captured headers, first failing check wins
  always_comb begin
    if (frame_len < udpc_pkg::MIN_ETH) begin
      verdict_o = udpc_pkg::VERDICT_SHORT_ETH;
    end else if (!is_v4 && !is_v6) begin
      verdict_o = udpc_pkg::VERDICT_NOT_IP;
    end else if (frame_len < (is_v4 ? udpc_pkg::MIN_V4_IP : udpc_pkg::MIN_V6_IP)) begin
      verdict_o = udpc_pkg::VERDICT_SHORT_IP;
    end else if (proto_d != udpc_pkg::PROTO_UDP) begin
      verdict_o = udpc_pkg::VERDICT_NOT_UDP;
    end else if (frame_len < (is_v4 ? udpc_pkg::MIN_V4_UDP : udpc_pkg::MIN_V6_UDP)) begin
      verdict_o = udpc_pkg::VERDICT_SHORT_UDP;
    end else if (dport_d != listen_port_i) begin
      verdict_o = udpc_pkg::VERDICT_PORT_MISMATCH;
    end else if ({1'b0, beat_i.queue} >= 7'(QUEUE_COUNT) || !mask_ext[beat_i.queue]) begin
      verdict_o = udpc_pkg::VERDICT_NO_SOCKET;
    end else begin
      verdict_o = udpc_pkg::VERDICT_REDIRECT;
    end
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      etype_q <= '0;
      proto_q <= '0;
      dport_q <= '0;
    end else if (adv_i) begin
      if (beat_i.last) begin
        count_q <= '0;
        etype_q <= '0;
        proto_q <= '0;
        dport_q <= '0;
      end else begin
        count_q <= count_d;
        etype_q <= etype_d;
        proto_q <= proto_d;
        dport_q <= dport_d;
      end
    end
  end

endmodule

@@ rtl/core/udp_port_packet_classifier.sv @@
// UDP destination port classifier for Ethernet frames.
// Input channel: one frame byte per beat (data_byte_i, last_byte_i, rx_queue_i)
// with in_valid_i / in_ready_o. rx_queue_i is used on the last byte only.
// Output channel: one verdict per frame (redirect_o, target_queue_o,
// verdict_code_o) with out_valid_o / out_ready_i, given after the last byte.
// Configuration: APB write to 0x0 sets the listen port, to 0x8 the 64-bit
// bound-queue mask; pready is always high and reads return the register.
// Throughput is one byte per cycle unless a last byte waits for the verdict
// register: every byte passes an input register, offset compares and captures,
// and (on the last byte) the verdict register, which then raises out_valid_o.
// When the receiver stalls, the verdict waits in the output register; bytes
// that are not last keep flowing, and a last byte is held in the input
// register, with in_ready_o low, until the verdict register frees up.
// Reset clears the frame state, the configuration registers and all valid flags.
module udp_port_packet_classifier #(
  parameter int QUEUE_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [5:0]  rx_queue_i,
  // verdict channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        redirect_o,
  output logic [5:0]  target_queue_o,
  output logic [2:0]  verdict_code_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic                   s1_valid_q;
  udpc_pkg::beat_t        s1_beat_q;
  logic                   out_valid_q;
  logic                   redirect_q;
  logic [5:0]             tqueue_q;
  udpc_pkg::verdict_e     verdict_q;
  udpc_pkg::verdict_e     verdict;
  logic [15:0]            port_q;
  logic [QUEUE_COUNT-1:0] mask_q;
  logic                   out_free;
  logic                   s1_adv;
  logic                   cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[3] == udpc_pkg::REG_QUEUE_MASK) ? 64'(mask_q) : 64'(port_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= '0;
      mask_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == udpc_pkg::REG_LISTEN_PORT) port_q <= pwdata[15:0];
      else mask_q <= pwdata[QUEUE_COUNT-1:0];
    end
  end

  // handshake: a last byte needs a free verdict register to move on
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_beat_q.last || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_beat_q.data  <= data_byte_i;
      s1_beat_q.last  <= last_byte_i;
      s1_beat_q.queue <= rx_queue_i;
    end
  end

  udpc_parser #(
    .QUEUE_COUNT(QUEUE_COUNT)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (s1_beat_q),
    .adv_i        (s1_adv),
    .listen_port_i(port_q),
    .queue_mask_i (mask_q),
    .verdict_o    (verdict)
  );

  // verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_beat_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_beat_q.last) begin
      verdict_q  <= verdict;
      redirect_q <= (verdict == udpc_pkg::VERDICT_REDIRECT);
      tqueue_q   <= (verdict == udpc_pkg::VERDICT_REDIRECT) ? s1_beat_q.queue : 6'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign redirect_o     = redirect_q;
  assign target_queue_o = tqueue_q;
  assign verdict_code_o = verdict_q;

endmodule
